>>> hdl/sma_pkg.sv
`default_nettype none
package sma_pkg;

  typedef logic [2:0] mode_t;
  localparam mode_t MODE_ADD  = 3'd0;
  localparam mode_t MODE_SUB  = 3'd1;
  localparam mode_t MODE_MUL  = 3'd2;
  localparam mode_t MODE_DIV  = 3'd3;
  localparam mode_t MODE_AND  = 3'd4;
  localparam mode_t MODE_LOAD = 3'd5;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_OVERFLOW = 2'd1;
  localparam status_t ST_DIVZERO  = 2'd2;
  localparam status_t ST_NOTDATA  = 2'd3;

  localparam int ModeW   = 3;
  localparam int StatusW = 2;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
  } dp_sts_t;

endpackage
`default_nettype wire

>>> hdl/sign_magnitude_accumulator_alu_top.sv
// Each item passes through the bit-per-cycle shift-add multiply / restoring
// divide loop; a new item is accepted only after the previous result has
// been taken from the output.
// Every mode runs the same loop, so timing does not depend on the data.
// Reset (rst_n low, synchronous) clears the accumulator to zero and idles the
// controller.
`default_nettype none
module sign_magnitude_accumulator_alu_top #(
  parameter int MAGNITUDE_BITS = 13,
  localparam int WordW = MAGNITUDE_BITS + 2,
  localparam int InW   = ((WordW + 3 + 7) / 8) * 8,
  localparam int OutW  = ((WordW + 2 + 7) / 8) * 8
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire logic [InW-1:0]  in_tdata,   // mode[2:0], memory_word
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output logic [OutW-1:0]      out_tdata   // accumulator_out, status
);
  import sma_pkg::*;

  dp_cmd_t          cmd;
  dp_sts_t          sts;
  logic [WordW-1:0] acc_word;
  status_t          status;

  sma_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  sma_dp #(
    .MAGNITUDE_BITS (MAGNITUDE_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_mode  (in_tdata[ModeW-1:0]),
    .in_word  (in_tdata[ModeW+WordW-1:ModeW]),
    .acc_word (acc_word),
    .status   (status)
  );

  assign out_tdata = OutW'({status, acc_word});

endmodule
`default_nettype wire

>>> hdl/sma_ctrl.sv
`default_nettype none
module sma_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output sma_pkg::dp_cmd_t      cmd,
  input  wire sma_pkg::dp_sts_t sts
);
  import sma_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_FIN  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        cmd.step = 1'b1;
        if (sts.last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.commit = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hdl/sma_dp.sv
`default_nettype none
module sma_dp #(
  parameter int MAGNITUDE_BITS = 13,
  localparam int WordW = MAGNITUDE_BITS + 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire sma_pkg::dp_cmd_t cmd,
  output sma_pkg::dp_sts_t      sts,
  input  wire sma_pkg::mode_t   in_mode,
  input  wire logic [WordW-1:0] in_word,
  output logic [WordW-1:0]      acc_word,
  output sma_pkg::status_t      status
);
  import sma_pkg::*;

  localparam int MB = MAGNITUDE_BITS;
  localparam int CntW = $clog2(MB);

  mode_t              mode_r;
  logic [WordW-1:0]   opd_r;
  logic [WordW-1:0]   acc_r, acc_nxt;
  status_t            st_r, st_nxt;
  logic [CntW-1:0]    cnt_r;
  logic [MB-1:0]      sh_r;
  logic [MB+1:0]      prod_r, prod_nxt;
  logic               movf_r, movf_nxt;
  logic [MB-1:0]      rem_r, rem_nxt;
  logic [MB-1:0]      quo_r;

  logic          sa, sb, sbe, tags_ok, qbit;
  logic [MB-1:0] ma, mb;
  logic [MB:0]   trial, msum;

  assign sa      = acc_r[MB];
  assign sb      = opd_r[MB];
  assign ma      = acc_r[MB-1:0];
  assign mb      = opd_r[MB-1:0];
  assign tags_ok = acc_r[MB+1] & opd_r[MB+1];
  assign sbe     = sb ^ (mode_r == MODE_SUB);
  assign msum    = {1'b0, ma} + {1'b0, mb};

  assign sts.last = (cnt_r == CntW'(MB - 1));

  // one multiplier bit / one quotient bit per step, MSB first
  always_comb begin
    prod_nxt = {prod_r[MB:0], 1'b0} + (sh_r[MB-1] ? {2'b00, ma} : '0);
    movf_nxt = movf_r | (prod_nxt[MB+1:MB] != 2'b00);
    trial    = {rem_r, sh_r[MB-1]};
    qbit     = (trial >= {1'b0, mb});
    rem_nxt  = qbit ? MB'(trial - {1'b0, mb}) : trial[MB-1:0];
  end

  always_comb begin
    acc_nxt = acc_r;
    st_nxt  = ST_OK;
    case (mode_r) inside
      MODE_ADD, MODE_SUB: begin
        if (!tags_ok) begin
          st_nxt = ST_NOTDATA;
        end else if (sa == sbe) begin
          if (msum[MB]) begin
            st_nxt = ST_OVERFLOW;
          end else begin
            acc_nxt = {1'b1, sa, msum[MB-1:0]};
          end
        end else if (ma > mb) begin
          acc_nxt = {1'b1, sa, MB'(ma - mb)};
        end else if (ma < mb) begin
          acc_nxt = {1'b1, sbe, MB'(mb - ma)};
        end else begin
          acc_nxt = {2'b10, {MB{1'b0}}};
        end
      end
      MODE_MUL: begin
        if (!tags_ok) begin
          st_nxt = ST_NOTDATA;
        end else if (movf_r) begin
          st_nxt = ST_OVERFLOW;
        end else begin
          acc_nxt = {1'b1, sa ^ sb, prod_r[MB-1:0]};
        end
      end
      MODE_DIV: begin
        if (!tags_ok) begin
          st_nxt = ST_NOTDATA;
        end else if (mb == '0) begin
          st_nxt = ST_DIVZERO;
        end else begin
          acc_nxt = {1'b1, sa ^ sb, quo_r};
        end
      end
      MODE_AND:  acc_nxt = acc_r & opd_r;
      MODE_LOAD: acc_nxt = opd_r;
      default:   acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      st_r  <= ST_OK;
      cnt_r <= '0;
    end else begin
      if (cmd.load) begin
        cnt_r <= '0;
      end else if (cmd.step) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.commit) begin
        st_r <= st_nxt;
        if (st_nxt == ST_OK) begin
          acc_r <= acc_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      opd_r  <= in_word;
      sh_r   <= (in_mode == MODE_DIV) ? acc_r[MB-1:0] : in_word[MB-1:0];
      prod_r <= '0;
      movf_r <= 1'b0;
      rem_r  <= '0;
      quo_r  <= '0;
    end else if (cmd.step) begin
      sh_r   <= {sh_r[MB-2:0], 1'b0};
      prod_r <= prod_nxt;
      movf_r <= movf_nxt;
      rem_r  <= rem_nxt;
      quo_r  <= {quo_r[MB-2:0], qbit};
    end
  end

  assign acc_word = acc_r;
  assign status   = st_r;

endmodule
`default_nettype wire
